[design/beu_pkg.sv]
package beu_pkg;

	localparam int RegCount   = 16;
	localparam int RegBits    = $clog2(RegCount);
	localparam int TableDepth = 256;
	localparam int TableBits  = $clog2(TableDepth);
	localparam int PcBits     = 18;
	localparam int QueueDepth = 2;

	localparam logic [4:0] OP_NOP   = 5'd1;
	localparam logic [4:0] OP_LOAD  = 5'd2;
	localparam logic [4:0] OP_ADD   = 5'd3;
	localparam logic [4:0] OP_SUB   = 5'd4;
	localparam logic [4:0] OP_MUL   = 5'd5;
	localparam logic [4:0] OP_DIV   = 5'd6;
	localparam logic [4:0] OP_AND   = 5'd7;
	localparam logic [4:0] OP_NOT   = 5'd8;
	localparam logic [4:0] OP_OR    = 5'd9;
	localparam logic [4:0] OP_XOR   = 5'd10;
	localparam logic [4:0] OP_ADDI  = 5'd11;
	localparam logic [4:0] OP_SUBI  = 5'd12;
	localparam logic [4:0] OP_MULI  = 5'd13;
	localparam logic [4:0] OP_DIVI  = 5'd14;
	localparam logic [4:0] OP_JMP   = 5'd15;
	localparam logic [4:0] OP_JNZ   = 5'd16;
	localparam logic [4:0] OP_JZ    = 5'd17;
	localparam logic [4:0] OP_JBT   = 5'd18;
	localparam logic [4:0] OP_JST   = 5'd19;
	localparam logic [4:0] OP_JNE   = 5'd20;
	localparam logic [4:0] OP_JE    = 5'd21;
	localparam logic [4:0] OP_JBE   = 5'd22;
	localparam logic [4:0] OP_JSE   = 5'd23;
	localparam logic [4:0] OP_CMP   = 5'd24;
	localparam logic [4:0] OP_INC   = 5'd25;
	localparam logic [4:0] OP_STORE = 5'd26;
	localparam logic [4:0] OP_GET   = 5'd27;
	localparam logic [4:0] OP_HALT  = 5'd28;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_ILL  = 2'd2;
	localparam logic [1:0] ST_DIV0 = 2'd3;

	typedef enum logic [3:0] {
		K_NONE, K_LOAD, K_ADD, K_SUB, K_MUL, K_DIV, K_AND, K_NOT, K_OR, K_XOR,
		K_INC, K_CMP, K_STORE, K_GET, K_JFLAG, K_JREG
	} kind_t;

	// classified instruction handed from front to back
	typedef struct packed {
		kind_t                 kind;
		logic [1:0]            status;
		logic [2:0]            len;
		logic [2:0]            cond;
		logic [RegBits-1:0]    ra;
		logic [RegBits-1:0]    rb;
		logic [31:0]           imm;
		logic [TableBits-1:0]  ti;
		logic [PcBits-1:0]     tgt;
	} uop_t;

	// cond codes
	localparam logic [2:0] C_ALWAYS = 3'd0;
	localparam logic [2:0] C_NZ     = 3'd1;
	localparam logic [2:0] C_Z      = 3'd2;
	localparam logic [2:0] C_NE     = 3'd3;
	localparam logic [2:0] C_E      = 3'd4;
	localparam logic [2:0] C_GT     = 3'd5;
	localparam logic [2:0] C_LT     = 3'd6;
	localparam logic [2:0] C_GE     = 3'd7;
	localparam logic [2:0] C_LE     = 3'd1;

endpackage

[design/beu_front.sv]
module beu_front
	import beu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [4:0]           func,
	input  logic [3:0]           reg_a,
	input  logic [3:0]           reg_b,
	input  logic signed [31:0]   immediate,
	input  logic [7:0]           table_index,
	input  logic [17:0]          target,
	output logic                 q_valid,
	input  logic                 q_ready,
	output uop_t                 q_uop
);

	uop_t                  mem_q [QueueDepth];
	logic [$clog2(QueueDepth)-1:0] wp_q, rp_q;
	logic [$clog2(QueueDepth):0]   cnt_q;
	uop_t                  u;
	logic                  push, pop;

	always_comb begin
		u        = '0;
		u.kind   = K_NONE;
		u.status = ST_RUN;
		u.len    = 3'd3;
		u.cond   = C_ALWAYS;
		u.ra     = reg_a[RegBits-1:0];
		u.rb     = reg_b[RegBits-1:0];
		u.imm    = immediate;
		u.ti     = table_index[TableBits-1:0];
		u.tgt    = target[PcBits-1:0];
		case (func) inside
			OP_NOP:                 u.len = 3'd1;
			OP_LOAD:                u.kind = K_LOAD;
			OP_ADD, OP_ADDI:        u.kind = K_ADD;
			OP_SUB, OP_SUBI:        u.kind = K_SUB;
			OP_MUL, OP_MULI:        u.kind = K_MUL;
			OP_DIV, OP_DIVI:        u.kind = K_DIV;
			OP_AND:                 u.kind = K_AND;
			OP_NOT:                 u.kind = K_NOT;
			OP_OR:                  u.kind = K_OR;
			OP_XOR:                 u.kind = K_XOR;
			OP_JMP: begin u.kind = K_JFLAG; u.len = 3'd2; u.cond = C_ALWAYS; end
			OP_JNZ: begin u.kind = K_JFLAG; u.cond = C_NZ; end
			OP_JZ:  begin u.kind = K_JFLAG; u.cond = C_Z; end
			OP_JNE: begin u.kind = K_JFLAG; u.len = 3'd2; u.cond = C_NE; end
			OP_JE:  begin u.kind = K_JFLAG; u.len = 3'd2; u.cond = C_E; end
			OP_JBT: begin u.kind = K_JREG; u.len = 3'd4; u.cond = C_GT; end
			OP_JST: begin u.kind = K_JREG; u.len = 3'd4; u.cond = C_LT; end
			OP_JBE: begin u.kind = K_JREG; u.len = 3'd4; u.cond = C_GE; end
			OP_JSE: begin u.kind = K_JREG; u.len = 3'd4; u.cond = C_LE; end
			OP_CMP:                 u.kind = K_CMP;
			OP_INC: begin u.kind = K_INC; u.len = 3'd2; end
			OP_STORE:               u.kind = K_STORE;
			OP_GET:                 u.kind = K_GET;
			OP_HALT: begin u.len = 3'd1; u.status = ST_HALT; end
			default: begin u.len = 3'd1; u.status = ST_ILL; end
		endcase
	end

	assign in_ready = (cnt_q != QueueDepth[$clog2(QueueDepth):0]);
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_uop    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= u;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{$clog2(QueueDepth){1'b0}}, push}
				- {{$clog2(QueueDepth){1'b0}}, pop};
		end
	end

endmodule

[design/beu_divider.sv]
module beu_divider
	import beu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] quot
);

	logic [31:0] rem_q, quo_q, div_q;
	logic        neg_q, busy_q;
	logic [4:0]  cnt_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	// restoring divide on magnitudes, one quotient bit per cycle
	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial   = {1'b0, shifted} - {1'b0, div_q};
	assign quot    = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			neg_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= a[31] ? (32'd0 - a) : a;
				div_q  <= b[31] ? (32'd0 - b) : b;
				neg_q  <= a[31] ^ b[31];
			end else if (busy_q) begin
				if (!trial[32]) rem_q <= trial[31:0];
				else rem_q <= shifted;
				quo_q <= {quo_q[30:0], ~trial[32]};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

[design/beu_back.sv]
module beu_back
	import beu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  uop_t                q_uop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [17:0]         next_pc,
	output logic                reg_write,
	output logic [3:0]          write_index,
	output logic signed [31:0]  write_value,
	output logic [5:0]          flags_out,
	output logic [1:0]          status
);

	typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_DIV, S_DONE} state_t;

	state_t               state_q;
	uop_t                 u_q;
	logic [31:0]          rf_q [RegCount];
	logic [31:0]          tbl_q [TableDepth];
	logic [TableDepth-1:0] tv_q;
	logic [31:0]          a_q, b_q, t_q, prod_q;
	logic [5:0]           flags_q;
	logic [PcBits-1:0]    pc_q;
	logic                 div_start, div_done;
	logic [31:0]          div_quot;
	logic [31:0]          val;
	logic                 wr, jmp;
	logic [31:0]          d;
	logic [5:0]           cf;
	logic                 sgt, slt;
	logic [PcBits-1:0]    npc;

	beu_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.a     (a_q),
		.b     (b_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign q_ready   = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign div_start = (state_q == S_READ) && (u_q.kind == K_DIV) && (b_q != '0);

	always_comb begin
		d   = a_q - b_q;
		sgt = $signed(a_q) > $signed(b_q);
		slt = $signed(a_q) < $signed(b_q);
		cf  = {a_q == b_q, $signed(d) > 0,
			(!a_q[31] && a_q != 0 && b_q[31] && d[31]) ||
			(a_q[31] && !b_q[31] && b_q != 0 && !d[31] && d != 0),
			a_q < b_q, d[31], d == 0};
		val = '0;
		wr  = 1'b1;
		jmp = 1'b0;
		unique case (u_q.kind)
			K_LOAD:  val = u_q.imm;
			K_ADD:   val = a_q + b_q;
			K_SUB:   val = d;
			K_MUL:   val = prod_q;
			K_DIV:   begin val = div_quot; wr = (b_q != '0); end
			K_AND:   val = a_q & b_q;
			K_NOT:   val = ~b_q;
			K_OR:    val = a_q | b_q;
			K_XOR:   val = a_q ^ b_q;
			K_INC:   val = a_q + 32'd1;
			K_GET:   val = t_q;
			K_JFLAG: begin
				wr = 1'b0;
				case (u_q.cond)
					C_NZ:    jmp = !flags_q[0];
					C_Z:     jmp = flags_q[0];
					C_NE:    jmp = !flags_q[5];
					C_E:     jmp = flags_q[5];
					default: jmp = 1'b1;
				endcase
			end
			K_JREG: begin
				wr = 1'b0;
				case (u_q.cond)
					C_GT:    jmp = sgt;
					C_LT:    jmp = slt;
					C_GE:    jmp = !slt;
					default: jmp = !sgt;
				endcase
			end
			default: wr = 1'b0;
		endcase
		npc = jmp ? u_q.tgt : pc_q + {{(PcBits-3){1'b0}}, u_q.len};
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ && u_q.kind == K_STORE) tbl_q[u_q.ti] <= u_q.imm;
		if (state_q == S_READ) t_q <= tbl_q[u_q.ti];
		prod_q <= a_q * b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			u_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
			for (int i = 0; i < RegCount; i++) rf_q[i] <= '0;
			tv_q      <= '0;
			flags_q   <= '0;
			pc_q      <= PcBits'(1);
			out_valid <= 1'b0;
			next_pc   <= '0;
			reg_write <= 1'b0;
			write_index <= '0;
			write_value <= '0;
			flags_out <= '0;
			status    <= ST_RUN;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid && q_ready) begin
					u_q     <= q_uop;
					a_q     <= rf_q[q_uop.ra];
					b_q     <= rf_q[q_uop.rb];
					state_q <= S_READ;
				end
				S_READ: begin
					if (u_q.kind == K_STORE) tv_q[u_q.ti] <= 1'b1;
					if (u_q.kind == K_MUL) state_q <= S_MUL;
					else if (div_start) state_q <= S_DIV;
					else state_q <= S_DONE;
				end
				S_MUL: state_q <= S_DONE;
				S_DIV: if (div_done) state_q <= S_DONE;
				S_DONE: begin
					// an unwritten table entry reads as zero
					if (wr) rf_q[u_q.ra] <= (u_q.kind == K_GET && !tv_q[u_q.ti]) ? '0 : val;
					if (u_q.kind == K_CMP) begin
						flags_q   <= cf;
						flags_out <= cf;
					end else begin
						flags_out <= flags_q;
					end
					pc_q        <= npc;
					next_pc     <= 18'(npc);
					reg_write   <= wr;
					write_index <= wr ? 4'(u_q.ra) : 4'd0;
					write_value <= wr ? ((u_q.kind == K_GET && !tv_q[u_q.ti]) ? '0 : val) : '0;
					status      <= (u_q.kind == K_DIV && b_q == '0) ? ST_DIV0 : u_q.status;
					out_valid   <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[design/bytecode_execute_unit.sv]
// Executes one fetched bytecode instruction per transfer and returns one result
// per instruction. A front stage decodes into a two-entry queue; the back stage
// reads registers, executes and registers the result. The back stage steps
// through read and done states; multiply adds a product state, and a nonzero
// divide waits on the iterative divider (one quotient bit per cycle). The next
// instruction enters once the prior result register is free or being taken.
module bytecode_execute_unit
	import beu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [4:0]          func,
	input  logic [3:0]          reg_a,
	input  logic [3:0]          reg_b,
	input  logic signed [31:0]  immediate,
	input  logic [7:0]          table_index,
	input  logic [17:0]         target,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [17:0]         next_pc,
	output logic                reg_write,
	output logic [3:0]          write_index,
	output logic signed [31:0]  write_value,
	output logic [5:0]          flags_out,
	output logic [1:0]          status
);

	logic q_valid, q_ready;
	uop_t q_uop;

	beu_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .reg_a(reg_a), .reg_b(reg_b), .immediate(immediate),
		.table_index(table_index), .target(target),
		.q_valid(q_valid), .q_ready(q_ready), .q_uop(q_uop)
	);

	beu_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_uop(q_uop), .out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .reg_write(reg_write), .write_index(write_index),
		.write_value(write_value), .flags_out(flags_out), .status(status)
	);

endmodule

[design/beu_checker.sv]
module beu_checker
	import beu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        reg_write,
	input logic [3:0]  write_index,
	input logic [31:0] write_value,
	input logic [1:0]  status,
	input logic [17:0] next_pc
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc))
		else $error("result dropped while stalled");

	a_nowr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_write |-> write_index == 4'd0 && write_value == 32'd0)
		else $error("write fields set without a write");

	a_div0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIV0 |-> !reg_write)
		else $error("register written on divide by zero");

	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_HALT || status == ST_ILL) |-> !reg_write)
		else $error("write on halt or illegal");

endmodule

bind bytecode_execute_unit beu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.reg_write(reg_write), .write_index(write_index), .write_value(write_value),
	.status(status), .next_pc(next_pc)
);
